// ===== rtl/mpti_pkg.sv =====
// ----------------------------------------------------------------------------
// mpti_pkg
// shared types and constants of the page table walker with insert on miss
// ----------------------------------------------------------------------------
package mpti_pkg;

	// address bits of one result word
	localparam int WORD_BITS = 32;

	// widest node index a level may cut from the address
	localparam int NODE_BITS_MAX = 16;

	// level registers in the register file
	localparam int LVL_REGS  = 4;
	localparam int LVL_IDX_W = 2;

	// register and field widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;
	localparam int LBITS_W    = 5;
	localparam int LVL_CNT_W  = 3;
	localparam int TOTAL_W    = 7;

	// register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEVEL_COUNT = 3'd0,
		REG_BITS_LEVEL0 = 3'd1,
		REG_BITS_LEVEL1 = 3'd2,
		REG_BITS_LEVEL2 = 3'd3,
		REG_BITS_LEVEL3 = 3'd4,
		REG_OFFSET_BITS = 3'd5
	} reg_idx_t;

	// register values after reset
	localparam logic [LVL_CNT_W-1:0] RST_LEVEL_COUNT = 3'd3;
	localparam logic [LBITS_W-1:0]   RST_BITS_LEVEL0 = 5'd4;
	localparam logic [LBITS_W-1:0]   RST_BITS_LEVEL1 = 5'd8;
	localparam logic [LBITS_W-1:0]   RST_BITS_LEVEL2 = 5'd8;
	localparam logic [LBITS_W-1:0]   RST_BITS_LEVEL3 = 5'd0;
	localparam logic [LBITS_W-1:0]   RST_OFFSET_BITS = 5'd12;

	// decoded configuration seen by the walker
	typedef struct packed {
		logic [LVL_REGS-1:0][LBITS_W-1:0] lbits;  // clamped to NODE_BITS_MAX
		logic [LVL_CNT_W-1:0]             nlev;   // levels in use
		logic [LBITS_W-1:0]               offs;   // page offset width
		logic [TOTAL_W-1:0]               total;  // index bits of levels in use
	} cfg_t;

endpackage

// ===== rtl/mpti_ram.sv =====
// ----------------------------------------------------------------------------
// mpti_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module mpti_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/mpti_cfg.sv =====
// ----------------------------------------------------------------------------
// mpti_cfg
// register file for the table shape, decoded into clamped level widths
// ----------------------------------------------------------------------------
module mpti_cfg #(
	parameter int MAX_LEVELS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mpti_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mpti_pkg::CFG_DATA_W-1:0] cfg_data,
	output mpti_pkg::cfg_t                 cfg,
	output logic                           restart
);

	logic [mpti_pkg::LVL_CNT_W-1:0]                          level_count_q;
	logic [mpti_pkg::LVL_REGS-1:0][mpti_pkg::LBITS_W-1:0]     bits_q;
	logic [mpti_pkg::LBITS_W-1:0]                            offs_q;
	logic                                                    wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;
	// any write to a register in the list restarts the table
	assign restart   = wr && (cfg_index <= mpti_pkg::REG_OFFSET_BITS);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_count_q <= mpti_pkg::RST_LEVEL_COUNT;
			bits_q[0]     <= mpti_pkg::RST_BITS_LEVEL0;
			bits_q[1]     <= mpti_pkg::RST_BITS_LEVEL1;
			bits_q[2]     <= mpti_pkg::RST_BITS_LEVEL2;
			bits_q[3]     <= mpti_pkg::RST_BITS_LEVEL3;
			offs_q        <= mpti_pkg::RST_OFFSET_BITS;
		end else if (wr) begin
			case (cfg_index)
				mpti_pkg::REG_LEVEL_COUNT: level_count_q <= cfg_data[mpti_pkg::LVL_CNT_W-1:0];
				mpti_pkg::REG_BITS_LEVEL0: bits_q[0] <= cfg_data;
				mpti_pkg::REG_BITS_LEVEL1: bits_q[1] <= cfg_data;
				mpti_pkg::REG_BITS_LEVEL2: bits_q[2] <= cfg_data;
				mpti_pkg::REG_BITS_LEVEL3: bits_q[3] <= cfg_data;
				mpti_pkg::REG_OFFSET_BITS: offs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp level widths and level count, sum the index bits in use
	always_comb begin
		logic [mpti_pkg::LVL_CNT_W-1:0] n;
		logic [mpti_pkg::TOTAL_W-1:0]   sum;
		n = level_count_q;
		if (n < mpti_pkg::LVL_CNT_W'(1)) begin
			n = mpti_pkg::LVL_CNT_W'(1);
		end
		if (n > mpti_pkg::LVL_CNT_W'(mpti_pkg::LVL_REGS)) begin
			n = mpti_pkg::LVL_CNT_W'(mpti_pkg::LVL_REGS);
		end
		if (MAX_LEVELS < mpti_pkg::LVL_REGS) begin
			if (n > mpti_pkg::LVL_CNT_W'(MAX_LEVELS)) begin
				n = mpti_pkg::LVL_CNT_W'(MAX_LEVELS);
			end
		end
		sum = '0;
		for (int i = 0; i < mpti_pkg::LVL_REGS; i++) begin
			if (bits_q[i] > mpti_pkg::LBITS_W'(mpti_pkg::NODE_BITS_MAX)) begin
				cfg.lbits[i] = mpti_pkg::LBITS_W'(mpti_pkg::NODE_BITS_MAX);
			end else begin
				cfg.lbits[i] = bits_q[i];
			end
			if (mpti_pkg::LVL_CNT_W'(i) < n) begin
				sum = sum + mpti_pkg::TOTAL_W'(cfg.lbits[i]);
			end
		end
		cfg.nlev  = n;
		cfg.offs  = offs_q;
		cfg.total = sum;
	end

endmodule

// ===== rtl/mpti_walk.sv =====
// ----------------------------------------------------------------------------
// mpti_walk
// sequencer that walks the radix table one level at a time through one
// slot ram, allocating nodes and frames on a miss
// ----------------------------------------------------------------------------
module mpti_walk #(
	parameter int SLOT_COUNT = 65536,
	parameter int ADDR_BITS  = 32,
	parameter int FRAME_BITS = 20
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mpti_pkg::cfg_t                  cfg,
	input  logic                            restart,
	input  logic                            start,
	input  logic [ADDR_BITS-1:0]            logical_address,
	output logic                            busy,
	output logic                            done,
	output logic                            was_hit,
	output logic [mpti_pkg::WORD_BITS-1:0]  vpn,
	output logic [FRAME_BITS-1:0]           pfn,
	output logic [mpti_pkg::WORD_BITS-1:0]  physical_address,
	output logic                            status
);

	localparam int NB    = mpti_pkg::NODE_BITS_MAX;
	localparam int AW    = $clog2(SLOT_COUNT);
	localparam int NFW   = AW + 1;
	localparam int SW    = ((AW > NB) ? AW : NB) + 1;
	localparam int SUMW  = SW + 1;
	localparam int PAY_W = (FRAME_BITS > AW) ? FRAME_BITS : AW;
	localparam int WW    = ADDR_BITS + NB;
	localparam int AMW   = ADDR_BITS + 1;
	localparam int PLW   = $clog2(ADDR_BITS + 1);
	localparam int WB    = mpti_pkg::WORD_BITS;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INDEX,
		ST_LOOK,
		ST_FINISH
	} state_t;

	state_t                          state_q;
	logic [AW-1:0]                   clr_q;
	logic [ADDR_BITS-1:0]            addr_q;
	logic [WW-1:0]                   work_q;
	logic [AW-1:0]                   base_q;
	logic [mpti_pkg::LVL_IDX_W-1:0]  lvl_q;
	logic [SW-1:0]                   slot_q;
	logic [NFW-1:0]                  next_free_q;
	logic [FRAME_BITS:0]             next_frame_q;
	logic [FRAME_BITS-1:0]           frame_q;
	logic                            hit_q;
	logic                            fail_q;
	logic                            done_q;
	logic                            was_hit_q;
	logic [WB-1:0]                   vpn_q;
	logic [FRAME_BITS-1:0]           pfn_q;
	logic [WB-1:0]                   physical_q;
	logic                            status_q;

	logic [mpti_pkg::LBITS_W-1:0]    b_cur;
	logic [NB-1:0]                   win;
	logic [NB-1:0]                   idx;
	logic [SW-1:0]                   slot;
	logic                            slot_oob;
	logic                            inner;
	logic [mpti_pkg::LVL_IDX_W-1:0]  lvl_nx;
	logic [SUMW-1:0]                 size;
	logic [SUMW-1:0]                 free_sum;
	logic                            alloc_fail;
	logic                            frame_fail;
	logic [SUMW-1:0]                 root_raw;
	logic [NFW-1:0]                  root;
	logic                            ram_we;
	logic [AW-1:0]                   ram_waddr;
	logic [PAY_W:0]                  ram_wdata;
	logic [PAY_W:0]                  ram_rdata;
	logic                            rd_valid;
	logic [PAY_W-1:0]                rd_pay;
	logic [PLW-1:0]                  page_lo;
	logic [AMW-1:0]                  low_wide;
	logic [ADDR_BITS-1:0]            low_mask;
	logic [ADDR_BITS-1:0]            page_shift;
	logic [WB-1:0]                   page_num;
	logic [WB-1:0]                   phys;

	// slot memory: valid bit over payload
	mpti_ram #(
		.WIDTH (PAY_W + 1),
		.DEPTH (SLOT_COUNT)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (slot[AW-1:0]),
		.rdata (ram_rdata)
	);

	// index cut and slot address of the current level
	always_comb begin
		b_cur    = cfg.lbits[lvl_q];
		win      = work_q[WW-1 -: NB];
		idx      = win >> (mpti_pkg::LBITS_W'(NB) - b_cur);
		slot     = SW'(base_q) + SW'(idx);
		slot_oob = slot >= SW'(SLOT_COUNT);
	end

	// decisions on the slot just read
	always_comb begin
		rd_valid   = ram_rdata[PAY_W];
		rd_pay     = ram_rdata[PAY_W-1:0];
		inner      = (mpti_pkg::LVL_CNT_W'(lvl_q) + mpti_pkg::LVL_CNT_W'(1)) < cfg.nlev;
		lvl_nx     = lvl_q + mpti_pkg::LVL_IDX_W'(1);
		size       = SUMW'(1) << cfg.lbits[lvl_nx];
		free_sum   = SUMW'(next_free_q) + size;
		alloc_fail = free_sum > SUMW'(SLOT_COUNT);
		frame_fail = next_frame_q[FRAME_BITS];
		root_raw   = SUMW'(1) << cfg.lbits[0];
		root       = (root_raw > SUMW'(SLOT_COUNT)) ? NFW'(SLOT_COUNT) : NFW'(root_raw);
	end

	// ram write: clearing sweep, node allocation or new frame
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q[AW-1:0];
		ram_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_LOOK: begin
				if (!rd_valid) begin
					if (inner && !alloc_fail) begin
						ram_we    = 1'b1;
						ram_wdata = {1'b1, PAY_W'(next_free_q)};
					end else if (!inner && !frame_fail) begin
						ram_we    = 1'b1;
						ram_wdata = {1'b1, PAY_W'(next_frame_q[FRAME_BITS-1:0])};
					end
				end
			end
			default: ;
		endcase
	end

	// page number and physical address
	always_comb begin
		if (cfg.total >= mpti_pkg::TOTAL_W'(ADDR_BITS)) begin
			page_lo = '0;
		end else begin
			page_lo = PLW'(ADDR_BITS) - PLW'(cfg.total);
		end
		low_wide   = (AMW'(1) << page_lo) - AMW'(1);
		low_mask   = low_wide[ADDR_BITS-1:0];
		page_shift = (addr_q & ~low_mask) >> cfg.offs;
		page_num   = WB'(page_shift);
		phys       = (WB'(frame_q) << cfg.offs) + WB'(addr_q & low_mask);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			addr_q       <= '0;
			work_q       <= '0;
			base_q       <= '0;
			lvl_q        <= '0;
			slot_q       <= '0;
			next_free_q  <= '0;
			next_frame_q <= '0;
			frame_q      <= '0;
			hit_q        <= 1'b0;
			fail_q       <= 1'b0;
			done_q       <= 1'b0;
			was_hit_q    <= 1'b0;
			vpn_q        <= '0;
			pfn_q        <= '0;
			physical_q   <= '0;
			status_q     <= 1'b0;
		end else if (restart) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			next_frame_q <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				// one slot a cycle back to invalid
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(SLOT_COUNT - 1)) begin
						next_free_q <= root;
						state_q     <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						addr_q  <= logical_address;
						work_q  <= {logical_address, NB'(0)};
						base_q  <= '0;
						lvl_q   <= '0;
						hit_q   <= 1'b0;
						fail_q  <= 1'b0;
						frame_q <= '0;
						state_q <= ST_INDEX;
					end
				end
				// slot address goes to the ram read port
				ST_INDEX: begin
					slot_q <= slot;
					work_q <= work_q << b_cur;
					if (slot_oob) begin
						fail_q  <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (inner) begin
						if (rd_valid) begin
							base_q  <= rd_pay[AW-1:0];
							lvl_q   <= lvl_nx;
							state_q <= ST_INDEX;
						end else if (alloc_fail) begin
							fail_q  <= 1'b1;
							state_q <= ST_FINISH;
						end else begin
							base_q      <= next_free_q[AW-1:0];
							next_free_q <= NFW'(free_sum);
							lvl_q       <= lvl_nx;
							state_q     <= ST_INDEX;
						end
					end else begin
						if (rd_valid) begin
							hit_q   <= 1'b1;
							frame_q <= rd_pay[FRAME_BITS-1:0];
						end else if (frame_fail) begin
							fail_q <= 1'b1;
						end else begin
							frame_q      <= next_frame_q[FRAME_BITS-1:0];
							next_frame_q <= next_frame_q + (FRAME_BITS + 1)'(1);
						end
						state_q <= ST_FINISH;
					end
				end
				// result word, shown for one cycle
				ST_FINISH: begin
					done_q    <= 1'b1;
					vpn_q     <= page_num;
					status_q  <= fail_q;
					was_hit_q <= hit_q && !fail_q;
					if (fail_q) begin
						pfn_q      <= '0;
						physical_q <= '0;
					end else begin
						pfn_q      <= frame_q;
						physical_q <= phys;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy             = (state_q != ST_IDLE);
	assign done             = done_q;
	assign was_hit          = was_hit_q;
	assign vpn              = vpn_q;
	assign pfn              = pfn_q;
	assign physical_address = physical_q;
	assign status           = status_q;

endmodule

// ===== rtl/multilevel_page_table_insert_top.sv =====
// ----------------------------------------------------------------------------
// multilevel_page_table_insert_top
// radix page table walker that inserts missing nodes and frames on demand
// ----------------------------------------------------------------------------
//  channel   handshake                    word
//  input     start, busy                  logical_address
//  result    done (one cycle strobe)      was_hit, vpn, pfn,
//                                         physical_address, status
//  config    cfg_valid, cfg_ready         cfg_index, cfg_data
//
//  an address runs ST_INDEX and ST_LOOK once per level, for the slot ram read
//  and update, then ST_FINISH; a walk that fails ends early. after reset and
//  after each write to a mapped register the slot ram is swept clear, one
//  slot at a time, with busy high; register writes are taken throughout
//  the result word stands for exactly one cycle under done, no back pressure
// ----------------------------------------------------------------------------
module multilevel_page_table_insert_top #(
	parameter int MAX_LEVELS = 4,
	parameter int SLOT_COUNT = 65536,
	parameter int ADDR_BITS  = 32,
	parameter int FRAME_BITS = 20
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [ADDR_BITS-1:0]            logical_address,
	output logic                            done,
	output logic                            was_hit,
	output logic [mpti_pkg::WORD_BITS-1:0]  vpn,
	output logic [FRAME_BITS-1:0]           pfn,
	output logic [mpti_pkg::WORD_BITS-1:0]  physical_address,
	output logic                            status,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mpti_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mpti_pkg::CFG_DATA_W-1:0] cfg_data
);

	mpti_pkg::cfg_t cfg;
	logic           restart;

	// table shape registers
	mpti_cfg #(
		.MAX_LEVELS (MAX_LEVELS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.restart   (restart)
	);

	// walker with its slot ram
	mpti_walk #(
		.SLOT_COUNT (SLOT_COUNT),
		.ADDR_BITS  (ADDR_BITS),
		.FRAME_BITS (FRAME_BITS)
	) u_walk (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.restart          (restart),
		.start            (start),
		.logical_address  (logical_address),
		.busy             (busy),
		.done             (done),
		.was_hit          (was_hit),
		.vpn              (vpn),
		.pfn              (pfn),
		.physical_address (physical_address),
		.status           (status)
	);

endmodule

// ===== tb/multilevel_page_table_insert_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_page_table_insert_top_tb
// drives logical addresses through the radix walker under a series of level
// layouts and checks every result word against a behavioural table kept in
// the testbench, covering hits, on-demand allocation and slot exhaustion
// ----------------------------------------------------------------------------
module multilevel_page_table_insert_top_tb;

	localparam int MAX_LEVELS = 4;
	localparam int SLOT_COUNT = 65536;
	localparam int ADDR_BITS  = 32;
	localparam int FRAME_BITS = 20;
	localparam int WB         = mpti_pkg::WORD_BITS;

	// settle time for a walk through every level plus margin, used once a phase has drained
	localparam int WALK_SETTLE = 2 * mpti_pkg::LVL_REGS + 4;
	// every mapped register write may cost a full sweep of the slot ram
	localparam longint CYCLE_LIMIT = 4_000_000;

	// register indexes past the end of the register file
	localparam logic [mpti_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [mpti_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct {
		bit                  hit;
		bit [WB-1:0]         page;
		bit [FRAME_BITS-1:0] frame;
		bit [WB-1:0]         phys;
		bit                  exhausted;
	} xlat_t;

	logic                            clk;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	logic [ADDR_BITS-1:0]            logical_address;
	logic                            done;
	logic                            was_hit;
	logic [WB-1:0]                   vpn;
	logic [FRAME_BITS-1:0]           pfn;
	logic [WB-1:0]                   physical_address;
	logic                            status;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [mpti_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [mpti_pkg::CFG_DATA_W-1:0] cfg_data;

	multilevel_page_table_insert_top #(
		.MAX_LEVELS(MAX_LEVELS),
		.SLOT_COUNT(SLOT_COUNT),
		.ADDR_BITS (ADDR_BITS),
		.FRAME_BITS(FRAME_BITS)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.logical_address (logical_address),
		.done            (done),
		.was_hit         (was_hit),
		.vpn             (vpn),
		.pfn             (pfn),
		.physical_address(physical_address),
		.status          (status),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// mirror of the register file and the radix table
	bit [mpti_pkg::LVL_CNT_W-1:0] tbl_levels;
	bit [mpti_pkg::LBITS_W-1:0]   tbl_bits [mpti_pkg::LVL_REGS];
	bit [mpti_pkg::LBITS_W-1:0]   tbl_offs;
	bit                           slot_live [SLOT_COUNT];
	int unsigned                  slot_data [SLOT_COUNT];
	longint unsigned              free_slot;
	longint unsigned              frame_next;

	xlat_t           pending_xlat [$];
	longint unsigned recent_addr [$];
	int unsigned     fault_count;
	longint          cycle_count = 0;
	bit              gap_free;

	function automatic int node_bits(int lvl);
		return (tbl_bits[lvl] > mpti_pkg::NODE_BITS_MAX) ?
			mpti_pkg::NODE_BITS_MAX : int'(tbl_bits[lvl]);
	endfunction

	function automatic int used_levels();
		int n;
		n = int'(tbl_levels);
		if (n < 1) n = 1;
		if (n > mpti_pkg::LVL_REGS) n = mpti_pkg::LVL_REGS;
		if (n > MAX_LEVELS) n = MAX_LEVELS;
		return n;
	endfunction

	// lowest address bit covered by the index fields
	function automatic int page_low();
		int total;
		int lo;
		total = 0;
		for (int l = 0; l < used_levels(); l++) total += node_bits(l);
		lo = ADDR_BITS - total;
		return (lo < 0) ? 0 : lo;
	endfunction

	// index field just below bit hi; positions under bit zero read as zero
	function automatic longint unsigned cut_index(longint unsigned a, int hi, int b);
		int lo;
		longint unsigned m;
		lo = hi - b;
		m = (64'd1 << b) - 1;
		if (b == 0 || hi <= 0) return 0;
		if (lo >= 0) return (a >> lo) & m;
		return ((a & ((64'd1 << hi) - 1)) << (-lo)) & m;
	endfunction

	function automatic void wipe_table();
		longint unsigned root;
		root = 64'd1 << node_bits(0);
		foreach (slot_live[i]) slot_live[i] = 1'b0;
		free_slot = (root > SLOT_COUNT) ? SLOT_COUNT : root;
		frame_next = 0;
	endfunction

	// any mapped register write starts the table afresh
	function automatic void apply_reg(logic [mpti_pkg::CFG_IDX_W-1:0] idx,
			logic [mpti_pkg::CFG_DATA_W-1:0] d);
		case (idx)
			mpti_pkg::REG_LEVEL_COUNT: tbl_levels = d[mpti_pkg::LVL_CNT_W-1:0];
			mpti_pkg::REG_BITS_LEVEL0: tbl_bits[0] = d;
			mpti_pkg::REG_BITS_LEVEL1: tbl_bits[1] = d;
			mpti_pkg::REG_BITS_LEVEL2: tbl_bits[2] = d;
			mpti_pkg::REG_BITS_LEVEL3: tbl_bits[3] = d;
			mpti_pkg::REG_OFFSET_BITS: tbl_offs = d;
			default: return;
		endcase
		wipe_table();
	endfunction

	// one walk with insert on miss, updating the mirrored table
	function automatic xlat_t walk(logic [ADDR_BITS-1:0] a);
		xlat_t r;
		longint unsigned amask, pmask, addr, base, slot, size, frame;
		int nlev, top, b, l;
		bit failed, hit;
		amask = (64'd1 << ADDR_BITS) - 1;
		addr = 64'(a);
		nlev = used_levels();
		pmask = amask & ~((64'd1 << page_low()) - 1);
		r.page = WB'((addr & pmask) >> tbl_offs);
		failed = 1'b0;
		hit = 1'b0;
		base = 0;
		frame = 0;
		top = ADDR_BITS;
		for (l = 0; l < nlev && !failed; l++) begin
			b = node_bits(l);
			slot = base + cut_index(addr, top, b);
			top -= b;
			if (slot >= SLOT_COUNT) begin
				failed = 1'b1;
			end else if (l + 1 < nlev) begin
				// inner level: follow or allocate the child node
				if (slot_live[slot]) begin
					base = 64'(slot_data[slot]);
				end else begin
					size = 64'd1 << node_bits(l + 1);
					if (free_slot + size > SLOT_COUNT) begin
						failed = 1'b1;
					end else begin
						slot_data[slot] = 32'(free_slot);
						slot_live[slot] = 1'b1;
						base = free_slot;
						free_slot += size;
					end
				end
			end else if (slot_live[slot]) begin
				hit = 1'b1;
				frame = 64'(slot_data[slot]);
			end else if (frame_next >= (64'd1 << FRAME_BITS)) begin
				failed = 1'b1;
			end else begin
				frame = frame_next;
				slot_data[slot] = 32'(frame);
				slot_live[slot] = 1'b1;
				frame_next++;
			end
		end
		r.hit = hit && !failed;
		r.exhausted = failed;
		if (failed) begin
			r.frame = '0;
			r.phys = '0;
		end else begin
			r.frame = FRAME_BITS'(frame);
			r.phys = WB'((frame << tbl_offs) + (addr & ~pmask & amask));
		end
		return r;
	endfunction

	function automatic bit take_gap();
		return !gap_free && ($urandom_range(99) < 21);
	endfunction

	// mostly revisits pages and shared prefixes so that walks go deep
	function automatic logic [ADDR_BITS-1:0] pick_address();
		int r;
		int k;
		longint unsigned p, lowm, a;
		r = $urandom_range(99);
		if (recent_addr.size() == 0 || r < 35) begin
			a = {32'd0, $urandom};
		end else begin
			p = recent_addr[$urandom_range(recent_addr.size() - 1)];
			if (r < 70) begin
				lowm = (64'd1 << page_low()) - 1;
			end else begin
				k = $urandom_range(ADDR_BITS - 1, 1);
				lowm = (64'd1 << (ADDR_BITS - k)) - 1;
			end
			a = (p & ~lowm) | ({32'd0, $urandom} & lowm);
		end
		a &= (64'd1 << ADDR_BITS) - 1;
		recent_addr.push_back(a);
		if (recent_addr.size() > 64) void'(recent_addr.pop_front());
		return a[ADDR_BITS-1:0];
	endfunction

	// one address word; start is left high until a later call sets it at a falling edge
	task automatic send_address(logic [ADDR_BITS-1:0] a);
		@(negedge clk);
		while (take_gap()) begin
			start = 1'b0;
			logical_address = $urandom;
			@(negedge clk);
		end
		start = 1'b1;
		logical_address = a;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_xlat.push_back(walk(a));
	endtask

	task automatic cfg_write(logic [mpti_pkg::CFG_IDX_W-1:0] idx,
			logic [mpti_pkg::CFG_DATA_W-1:0] d);
		@(negedge clk);
		while (take_gap()) begin
			cfg_valid = 1'b0;
			@(negedge clk);
		end
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(idx, d);
	endtask

	task automatic cfg_release();
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// wait until the walker has nothing outstanding
	task automatic drain_walks();
		@(negedge clk);
		start = 1'b0;
		while (pending_xlat.size() != 0) @(posedge clk);
		repeat (WALK_SETTLE) @(posedge clk);
	endtask

	task automatic run_random(int count);
		for (int i = 0; i < count; i++) begin
			gap_free = (i >= count / 3) && (i < count / 3 + 40);
			send_address(pick_address());
		end
		gap_free = 1'b0;
	endtask

	// reset layout: three levels of 4, 8, 8 bits, 4k pages
	task automatic test_default_layout();
		recent_addr.delete();
		send_address(32'h0000_0000);
		send_address(32'h0000_0FFF);
		send_address(32'hFFFF_FFFF);
		send_address(32'hFFFF_F000);
		send_address(32'h8000_0000);
		send_address(32'h7FFF_FFFF);
		send_address(32'h1234_5678);
		send_address(32'h1234_5ABC);
		send_address(32'h1235_0000);
		send_address(32'hA5A5_A5A5);
		send_address(32'h5A5A_5A5A);
		send_address(32'h0000_1000);
		send_address(32'h0010_0000);
		send_address(32'h1000_0000);
		run_random(150);
	endtask

	// level count above four is clamped to four
	task automatic test_four_levels();
		drain_walks();
		cfg_write(mpti_pkg::REG_LEVEL_COUNT, 5'b11111);
		cfg_write(mpti_pkg::REG_BITS_LEVEL3, 5'd4);
		cfg_write(mpti_pkg::REG_OFFSET_BITS, 5'd8);
		cfg_release();
		recent_addr.delete();
		send_address(32'h0000_0000);
		send_address(32'hFFFF_FFFF);
		send_address(32'hFFFF_FF00);
		send_address(32'h8000_00FF);
		run_random(150);
	endtask

	// 10 + 8 + 8 + 8 index bits: the last field runs below bit zero
	task automatic test_index_past_bit_zero();
		drain_walks();
		cfg_write(mpti_pkg::REG_BITS_LEVEL0, 5'd10);
		cfg_write(mpti_pkg::REG_BITS_LEVEL3, 5'd8);
		cfg_write(mpti_pkg::REG_OFFSET_BITS, 5'd0);
		cfg_release();
		recent_addr.delete();
		send_address(32'hFFFF_FFFF);
		send_address(32'hFFFF_FFFC);
		send_address(32'h0000_003F);
		send_address(32'h0000_003F);
		run_random(150);
	endtask

	// level count zero means one level; oversized level bits clamp to 16
	task automatic test_single_wide_level();
		drain_walks();
		cfg_write(mpti_pkg::REG_LEVEL_COUNT, 5'b11000);
		cfg_write(mpti_pkg::REG_BITS_LEVEL0, 5'b11111);
		cfg_write(mpti_pkg::REG_OFFSET_BITS, 5'd31);
		cfg_release();
		recent_addr.delete();
		send_address(32'h0000_0000);
		send_address(32'hFFFF_FFFF);
		send_address(32'h8000_FFFF);
		send_address(32'h8000_0000);
		run_random(140);
	endtask

	// only three 16k nodes fit behind a 16 entry root
	task automatic test_slot_exhaustion();
		drain_walks();
		cfg_write(mpti_pkg::REG_LEVEL_COUNT, 5'd2);
		cfg_write(mpti_pkg::REG_BITS_LEVEL0, 5'd4);
		cfg_write(mpti_pkg::REG_BITS_LEVEL1, 5'd14);
		cfg_write(mpti_pkg::REG_OFFSET_BITS, 5'd12);
		cfg_release();
		recent_addr.delete();
		send_address(32'h0000_0000);
		send_address(32'h1000_0000);
		send_address(32'h2000_0000);
		send_address(32'h3000_0000);
		send_address(32'h0000_4000);
		send_address(32'h3000_0000);
		run_random(150);
	endtask

	// one entry middle nodes; writes to unmapped indexes keep the table
	task automatic test_empty_nodes_spare_regs();
		drain_walks();
		cfg_write(mpti_pkg::REG_LEVEL_COUNT, 5'd3);
		cfg_write(mpti_pkg::REG_BITS_LEVEL0, 5'd8);
		cfg_write(mpti_pkg::REG_BITS_LEVEL1, 5'd0);
		cfg_write(mpti_pkg::REG_BITS_LEVEL2, 5'd8);
		cfg_write(mpti_pkg::REG_OFFSET_BITS, 5'd16);
		cfg_release();
		recent_addr.delete();
		send_address(32'h0000_0000);
		send_address(32'hFFFF_FFFF);
		run_random(80);
		drain_walks();
		cfg_write(REG_SPARE_LO, mpti_pkg::CFG_DATA_W'($urandom_range(31)));
		cfg_write(REG_SPARE_HI, mpti_pkg::CFG_DATA_W'($urandom_range(31)));
		cfg_release();
		run_random(80);
	endtask

	// a full size root leaves no room for any child node
	task automatic test_full_root();
		drain_walks();
		cfg_write(mpti_pkg::REG_LEVEL_COUNT, 5'd2);
		cfg_write(mpti_pkg::REG_BITS_LEVEL0, 5'd16);
		cfg_write(mpti_pkg::REG_BITS_LEVEL1, 5'd16);
		cfg_write(mpti_pkg::REG_BITS_LEVEL3, 5'd16);
		cfg_release();
		recent_addr.delete();
		send_address(32'hFFFF_FFFF);
		send_address(32'h0000_0000);
		run_random(60);
	endtask

	task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
		$display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
		fault_count++;
	endtask

	// compare each result word with the oldest outstanding translation
	always @(posedge clk) begin
		xlat_t want;
		if (arst_n && done) begin
			if (pending_xlat.size() == 0) begin
				$display("%0t ns: unexpected result word, page %0h", $time, vpn);
				fault_count++;
			end else begin
				want = pending_xlat.pop_front();
				if (was_hit !== want.hit) note_mismatch("was_hit", want.hit, was_hit);
				if (vpn !== want.page)
					note_mismatch("vpn", want.page, vpn);
				if (pfn !== want.frame)
					note_mismatch("pfn", want.frame, pfn);
				if (physical_address !== want.phys)
					note_mismatch("physical_address", want.phys, physical_address);
				if (status !== want.exhausted)
					note_mismatch("status", want.exhausted, status);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[multilevel_page_table_insert_top] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		logical_address = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fault_count = 0;
		gap_free = 1'b0;
		tbl_levels = mpti_pkg::RST_LEVEL_COUNT;
		tbl_bits[0] = mpti_pkg::RST_BITS_LEVEL0;
		tbl_bits[1] = mpti_pkg::RST_BITS_LEVEL1;
		tbl_bits[2] = mpti_pkg::RST_BITS_LEVEL2;
		tbl_bits[3] = mpti_pkg::RST_BITS_LEVEL3;
		tbl_offs = mpti_pkg::RST_OFFSET_BITS;
		wipe_table();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_default_layout();
		test_four_levels();
		test_index_past_bit_zero();
		test_single_wide_level();
		test_slot_exhaustion();
		test_empty_nodes_spare_regs();
		test_full_root();
		drain_walks();

		if (fault_count == 0)
			$display("[multilevel_page_table_insert_top] OK");
		else
			$display("[multilevel_page_table_insert_top] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/mpti_pkg.sv
rtl/mpti_ram.sv
rtl/mpti_cfg.sv
rtl/mpti_walk.sv
rtl/multilevel_page_table_insert_top.sv
tb/multilevel_page_table_insert_top_tb.sv
